/* src/bounded_list_engine_defines.svh */
// ----------------------------------------------------------------------------
// bounded_list_engine_defines.svh
// Assertion macros shared by the list engine modules.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_LIST_ENGINE_DEFINES_SVH

// property holds at every clock edge out of reset
`define BLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when cond holds, prop holds at the next edge
`define BLE_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* src/ble_pkg.sv */
// ----------------------------------------------------------------------------
// ble_pkg
// Sizes, request and status codes, and the result record of the list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PW    = (CW > 8) ? CW : 8;   // width for position compares

  localparam int VAL_W = 32;
  localparam int OCC_W = 5;

  // request kinds
  localparam logic [2:0] REQ_ADD_FRONT = 3'd0;
  localparam logic [2:0] REQ_ADD_BACK  = 3'd1;
  localparam logic [2:0] REQ_ADD_POS   = 3'd2;
  localparam logic [2:0] REQ_REM_FRONT = 3'd3;
  localparam logic [2:0] REQ_REM_BACK  = 3'd4;
  localparam logic [2:0] REQ_LIST      = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] element;
    logic [OCC_W-1:0]        occupancy;
    logic                    last_item;
  } ble_res_t;

endpackage

/* src/bounded_list_engine.sv */
// ----------------------------------------------------------------------------
// bounded_list_engine
// Ordered store of up to DEPTH signed 32-bit values with front/back/position
// insert, front/back remove and in-order listing, over stream channels.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_tready is high only while the sequencer
// is idle. The elements live in one RAM with a single write and a single
// registered read port, and every move of an element is a read, then a
// write. Append, remove from back, rejected requests and unknown kinds move
// no entries; insert at position p moves the entries from p upwards one by
// one, remove from front moves every entry behind the first down one slot,
// and a list reads the elements one by one, offering each as a result. After
// the last result the sequencer returns to idle before the next request
// is accepted. A result register sits on the output, so a stalled out_tready
// holds the sequencer only when a new result is ready to enter it. No
// clearing pass is needed after reset: only entries below the element count
// are ever read.
// ----------------------------------------------------------------------------
module bounded_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] value
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] element, [36:32] occupancy, [39:37] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last_item
);
  import ble_pkg::*;

  logic     res_valid, res_ready;
  ble_res_t res;

  // output holding register
  logic     out_valid_r, out_valid_nxt;
  ble_res_t out_data_r, out_data_nxt;

  ble_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_position (in_tdata[7:0]),
    .in_value    (in_tdata[39:8]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // a new result may enter when the register is empty or is being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r.occupancy, out_data_r.element};
  assign out_tuser  = out_data_r.status;
  assign out_tlast  = out_data_r.last_item;

endmodule

/* src/ble_ram.sv */
// ----------------------------------------------------------------------------
// ble_ram
// Generic single-write, single-read RAM; read data registered and held
// while no read is issued.
// ----------------------------------------------------------------------------
module ble_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/ble_ctrl.sv */
// ----------------------------------------------------------------------------
// ble_ctrl
// Sequencer of the list engine: decodes a request, walks the element RAM
// one entry at a time with a shared index step unit, and issues results.
// ----------------------------------------------------------------------------
`include "bounded_list_engine_defines.svh"

module ble_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_kind,
  input  logic [7:0]                     in_position,
  input  logic signed [ble_pkg::VAL_W-1:0] in_value,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ble_pkg::ble_res_t              res
);
  import ble_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP_RD  = 4'd1;
  localparam logic [3:0] S_UP_WR  = 4'd2;
  localparam logic [3:0] S_INS    = 4'd3;
  localparam logic [3:0] S_DN_RD  = 4'd4;
  localparam logic [3:0] S_DN_WR  = 4'd5;
  localparam logic [3:0] S_LS_RD  = 4'd6;
  localparam logic [3:0] S_LS_OUT = 4'd7;
  localparam logic [3:0] S_RES    = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    tgt_r, tgt_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [1:0]       status_r, status_nxt;

  // shared index step unit: decrement while opening a gap, else increment
  logic          step_dec;
  logic [AW-1:0] idx_step;
  logic [AW-1:0] last_idx;
  logic [PW-1:0] tgt_pw;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [VAL_W-1:0] wr_data, rd_data;

  assign step_dec = (state_r == S_UP_RD) || (state_r == S_UP_WR);
  assign idx_step = step_dec ? (idx_r - AW'(1)) : (idx_r + AW'(1));
  assign last_idx = AW'(count_r - CW'(1));

  ble_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    unique case (in_kind)
      REQ_ADD_FRONT: tgt_pw = '0;
      REQ_ADD_BACK:  tgt_pw = PW'(count_r);
      default:       tgt_pw = PW'(in_position);
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    tgt_nxt    = tgt_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    res.status    = status_r;
    res.element   = '0;
    res.occupancy = OCC_W'(count_r);
    res.last_item = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt  = S_RES;
          status_nxt = ST_OK;
          unique case (in_kind) inside
            REQ_ADD_FRONT, REQ_ADD_BACK, REQ_ADD_POS: begin
              if (count_r >= CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else if (tgt_pw > PW'(count_r)) begin
                status_nxt = ST_BADPOS;
              end else if (tgt_pw == PW'(count_r)) begin
                // append: no entries move
                wr_en     = 1'b1;
                wr_addr   = AW'(count_r);
                wr_data   = in_value;
                count_nxt = count_r + CW'(1);
              end else begin
                // open a gap: idx is the destination slot, walking down
                idx_nxt   = AW'(count_r);
                tgt_nxt   = AW'(tgt_pw);
                val_nxt   = in_value;
                state_nxt = S_UP_RD;
              end
            end
            REQ_REM_FRONT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (count_r == CW'(1)) begin
                count_nxt = '0;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DN_RD;
              end
            end
            REQ_REM_BACK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            REQ_LIST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_LS_RD;
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_UP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_step;
        state_nxt = S_UP_WR;
      end
      S_UP_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        idx_nxt = idx_step;
        state_nxt = (idx_step == tgt_r) ? S_INS : S_UP_RD;
      end
      S_INS: begin
        wr_en      = 1'b1;
        wr_addr    = tgt_r;
        wr_data    = val_r;
        count_nxt  = count_r + CW'(1);
        status_nxt = ST_OK;
        state_nxt  = S_RES;
      end
      S_DN_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_step;
        state_nxt = S_DN_WR;
      end
      S_DN_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        idx_nxt = idx_step;
        if (idx_step == last_idx) begin
          count_nxt  = count_r - CW'(1);
          status_nxt = ST_OK;
          state_nxt  = S_RES;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_LS_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_LS_OUT;
      end
      S_LS_OUT: begin
        res_valid     = 1'b1;
        res.status    = ST_OK;
        res.element   = rd_data;
        res.last_item = (idx_r == last_idx);
        if (res_ready) begin
          idx_nxt   = idx_step;
          state_nxt = (idx_r == last_idx) ? S_IDLE : S_LS_RD;
        end
      end
      S_RES: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
    end
    idx_r    <= idx_nxt;
    tgt_r    <= tgt_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
  end

  `BLE_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "element count above depth")
  `BLE_ASSERT(a_idle_no_result, in_ready |-> !res_valid, "result offered while idle")
  `BLE_ASSERT(a_gap_above_target, (state_r == S_UP_WR) |-> (idx_r > tgt_r), "shift passed target")
  `BLE_ASSERT_NEXT(a_idle_hold, in_ready && !in_valid, $stable(count_r), "count moved while idle")

endmodule

/* test/ble_result_checker.sv */
// ----------------------------------------------------------------------------
// ble_result_checker
// Watches both stream channels of the list engine. Keeps its own copy of the
// held elements, works out the results of every accepted request and compares
// each returned result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module ble_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] value
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] element, [36:32] occupancy, [39:37] zero
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic        out_tlast,  // last_item
  output int          fail_count,
  output int          pending
);
  import ble_pkg::*;

  logic signed [VAL_W-1:0] held_values [DEPTH];
  int                      held_count = 0;
  ble_res_t                expected_results [$];
  int                      mismatches = 0;

  task automatic push_result(input logic [1:0] st, input logic signed [VAL_W-1:0] elem,
                             input logic last);
    ble_res_t r;
    r.status    = st;
    r.element   = elem;
    r.occupancy = OCC_W'(held_count);
    r.last_item = last;
    expected_results.push_back(r);
  endtask

  // full is checked before the position
  task automatic insert_value(input int pos, input logic signed [VAL_W-1:0] val,
                              output logic [1:0] st);
    int i;
    st = ST_OK;
    if (held_count >= DEPTH) begin
      st = ST_FULL;
    end else if (pos > held_count) begin
      st = ST_BADPOS;
    end else begin
      for (i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
      held_values[pos] = val;
      held_count++;
    end
  endtask

  task automatic apply_request(input logic [2:0] kind, input logic [7:0] pos,
                               input logic signed [VAL_W-1:0] val);
    logic [1:0] st;
    int         i;
    st = ST_OK;
    case (kind)
      REQ_ADD_FRONT: insert_value(0, val, st);
      REQ_ADD_BACK:  insert_value(held_count, val, st);
      REQ_ADD_POS:   insert_value(int'(pos), val, st);
      REQ_REM_FRONT: begin
        if (held_count == 0) begin
          st = ST_EMPTY;
        end else begin
          for (i = 0; i < held_count - 1; i++) held_values[i] = held_values[i+1];
          held_count--;
        end
      end
      REQ_REM_BACK: begin
        if (held_count == 0) st = ST_EMPTY;
        else held_count--;
      end
      REQ_LIST: begin
        if (held_count == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < held_count; i++)
            push_result(ST_OK, held_values[i], i == held_count - 1);
        end
      end
      default: ;  // spare kinds: no change, plain ok
    endcase
    if (kind != REQ_LIST) push_result(st, '0, 1'b1);
  endtask

  always @(posedge clk) begin : monitor
    ble_res_t got;
    ble_res_t want;
    if (!rst_n) begin
      expected_results.delete();
      held_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status    = out_tuser;
        got.element   = out_tdata[31:0];
        got.occupancy = out_tdata[36:32];
        got.last_item = out_tlast;
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status %0d element %0d occupancy %0d last %0b",
                     got.status, got.element, got.occupancy, got.last_item);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.element !== want.element ||
              got.occupancy !== want.occupancy || got.last_item !== want.last_item) begin
            if (mismatches < 10) begin
              $display("mismatch: expected status %0d element %0d occupancy %0d last %0b",
                       want.status, want.element, want.occupancy, want.last_item);
              $display("          got      status %0d element %0d occupancy %0d last %0b",
                       got.status, got.element, got.occupancy, got.last_item);
            end
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) apply_request(in_tuser, in_tdata[7:0], in_tdata[39:8]);
    end
    fail_count <= mismatches;
    pending    <= expected_results.size();
  end

endmodule

/* test/tb_bounded_list_engine.sv */
// ----------------------------------------------------------------------------
// tb_bounded_list_engine
// Drives requests into the list engine and gives the verdict. A directed
// opening walks the empty, single-element and full corners; a long random
// run then swings the store between filling and draining. Both channels
// idle in random bursts, and once the receiver holds off long enough that
// the engine must stall its input. Results are checked by ble_result_checker.
// ----------------------------------------------------------------------------
module tb_bounded_list_engine;
  import ble_pkg::*;

  localparam int N_RANDOM        = 500;
  localparam int CALM_TAIL       = 60;    // last items run without idling
  localparam int HOLD_OFF_AT     = 120;   // random item that triggers the long stall
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no item on either side
  localparam int DRAIN_CYCLES    = 40;

  // kinds the engine does not define; they must answer a plain ok
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [7:0] position, [39:8] value
  logic [2:0]  in_tuser;   // [2:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] element, [36:32] occupancy, [39:37] zero
  logic [1:0]  out_tuser;  // [1:0] status
  logic        out_tlast;  // last_item

  int fail_count;
  int pending;
  int idle_cycles;

  bit calm          = 1'b0;  // set for the tail: no idling on either side
  bit hold_off_now  = 1'b0;  // sender asks the receiver for the long stall
  bit hold_off_done = 1'b0;  // receiver has served the long stall
  int idle_pct      = 20;    // chance in percent of a gap before an item

  bounded_list_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ble_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: any cycle that moves an item on either side resets the count.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none in the tail.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_now && !hold_off_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Half the time an extreme of the signed range, zero or minus one, otherwise any pattern.
  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Offers one item, optionally after a gap, and returns at the edge that takes it.
  task automatic send_request(input logic [2:0] kind, input logic [7:0] pos,
                              input logic [31:0] val);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {val, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int         i;
    int         mood_left;
    bit         growing;
    logic [2:0] kind;
    logic [7:0] pos;
    int         r;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty store corners and the spare kinds
    send_request(REQ_LIST, 8'd0, 32'd0);
    send_request(REQ_REM_FRONT, 8'd0, 32'd0);
    send_request(REQ_REM_BACK, 8'hff, 32'hffff_ffff);
    send_request(REQ_SPARE_6, 8'hff, 32'hffff_ffff);
    send_request(REQ_SPARE_7, 8'h00, 32'h0);
    send_request(REQ_ADD_POS, 8'd1, 32'h1234_5678);      // bad position on empty
    // single element removed from either end
    send_request(REQ_ADD_POS, 8'd0, 32'h7fff_ffff);
    send_request(REQ_REM_FRONT, 8'd0, 32'd0);
    send_request(REQ_ADD_BACK, 8'd0, 32'h8000_0000);
    send_request(REQ_REM_BACK, 8'd0, 32'd0);
    // fill to capacity with a mix of inserts
    for (i = 0; i < DEPTH; i++) begin
      case (i % 3)
        0:       send_request(REQ_ADD_FRONT, 8'd0, random_value());
        1:       send_request(REQ_ADD_BACK, 8'd0, random_value());
        default: send_request(REQ_ADD_POS, 8'($urandom_range(0, i)), random_value());
      endcase
    end
    // full wins over a bad position
    send_request(REQ_ADD_FRONT, 8'd0, 32'h1);
    send_request(REQ_ADD_POS, 8'hff, 32'h2);
    send_request(REQ_ADD_BACK, 8'd0, 32'h3);
    send_request(REQ_LIST, 8'd0, 32'd0);

    // Random part: the store swings between growing and shrinking phases so
    // that the full and empty corners come up again and again.
    growing   = 1'b0;
    mood_left = 0;
    for (i = 0; i < N_RANDOM; i++) begin
      if (mood_left == 0) begin
        growing   = !growing;
        mood_left = $urandom_range(20, 40);
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      mood_left--;
      if (i == HOLD_OFF_AT) hold_off_now = 1'b1;
      if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;

      r = $urandom_range(0, 99);
      if (r < (growing ? 70 : 25)) begin
        case ($urandom_range(0, 2))
          0:       kind = REQ_ADD_FRONT;
          1:       kind = REQ_ADD_BACK;
          default: kind = REQ_ADD_POS;
        endcase
      end else if (r < 85) begin
        kind = $urandom_range(0, 1) ? REQ_REM_FRONT : REQ_REM_BACK;
      end else if (r < 97) begin
        kind = REQ_LIST;
      end else begin
        kind = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
      end

      // positions mostly near the count, sometimes far beyond it
      if (kind == REQ_ADD_POS && $urandom_range(0, 9) < 8) pos = 8'($urandom_range(0, 17));
      else pos = 8'($urandom_range(0, 255));

      send_request(kind, pos, random_value());
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
